FILE: rtl/owm_pkg.sv
// Shared types, register indexes, commands and reset defaults for the one-wire bus master.
package owm_pkg;

   localparam int REG_W               = 10;
   localparam int NUM_REGS            = 8;
   localparam int REG_INDEX_W         = 3;
   localparam int DEFAULT_COUNT_WIDTH = 10;

   typedef enum logic [REG_INDEX_W-1:0] {
      REG_RESET_LOW,
      REG_PRES_WAIT,
      REG_RESET_REC,
      REG_SHORT_LOW,
      REG_WRITE_SLOT,
      REG_WRITE_REC,
      REG_READ_SLOT,
      REG_READ_TAIL
   } reg_index_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_RESET,
      CMD_WRITE,
      CMD_READ
   } cmd_type;

   localparam logic [REG_W-1:0] REG_DEFAULTS [NUM_REGS] = '{
      10'd800, 10'd60, 10'd800, 10'd1, 10'd80, 10'd5, 10'd60, 10'd50
   };

endpackage

FILE: rtl/owm_req_if.sv
// Request channel: one beat per tick or command.
interface owm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] data_byte;
   logic       line_in;

   modport source (output valid, cmd, data_byte, line_in, input ready);
   modport sink   (input valid, cmd, data_byte, line_in, output ready);
endinterface

FILE: rtl/owm_rsp_if.sv
// Response channel: one beat per accepted request beat.
interface owm_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       reset_level;

   modport source (output valid, drive_low, busy_res, done_res, read_data, reset_level,
                   input ready);
   modport sink   (input valid, drive_low, busy_res, done_res, read_data, reset_level,
                   output ready);
endinterface

FILE: rtl/one_wire_bus_master.sv
// One-wire bus master top level: phase sequencer, bit counters and response register.
//
// Usage: each request beat is one microsecond tick. A beat carries cmd (tick, reset,
// write byte, read byte), data_byte for a write and line_in, the bus level sampled on
// that tick. Commands are taken only while idle; a command given while busy is ignored
// and the beat counts as an ordinary tick.
// Every request beat yields exactly one response beat: drive_low for the open-drain
// pad, busy_res, done_res on the beat that ends a sequence, read_data (last byte
// read, LSB first) and reset_level (presence sample, low when a device answered).
// The sequencer updates on the accepting edge and the response register shows the result
// on the next cycle. Throughput is one beat per cycle while the receiver keeps up; the
// figure is set by the single response register, which is refilled in the cycle it
// drains. When the receiver stalls, the response holds and req ready drops until it
// is taken, so the phase counter stops with it (timing is counted in beats).
// The user must write timing registers on the csr port only while idle (not enforced);
// each phase lasts its register value plus one beats, clamped to the counter width.
// Reset (synchronous, active high) returns to idle, clears counters and bytes, sets
// the presence level high, restores register defaults and empties the response.
module one_wire_bus_master
   import owm_pkg::*;
#(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   owm_req_if.sink                req_bus,
   owm_rsp_if.source              rsp_bus,
   input  logic                   csr_write_en,
   input  logic [REG_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_write_data
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_WAIT,
      PH_RST_REC,
      PH_W_LOW,
      PH_W_REL,
      PH_R_LOW,
      PH_R_REL,
      PH_R_TAIL
   } phase_type;

   logic [COUNT_WIDTH-1:0] limit [NUM_REGS];

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [2:0]             bit_index_ff, bit_index_in;
   logic [7:0]             tx_shift_ff, tx_shift_in;
   logic [7:0]             rx_byte_ff, rx_byte_in;
   logic                   presence_ff, presence_in;
   logic                   done_in;

   logic                   rsp_valid_ff;
   logic                   drive_low_ff, busy_ff, done_ff;

   logic                   req_beat;
   logic [COUNT_WIDTH-1:0] phase_lim;
   logic                   tx_one;

   owm_timing_regs #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_timing_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .limit          (limit)
   );

   // response register drains and refills in the same cycle
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_beat      = req_bus.valid && req_bus.ready;

   assign tx_one = tx_shift_ff[0];

   // limit of the phase in effect; write timing follows the current bit
   always_comb begin
      unique case (phase_ff)
         PH_RST_LOW:  phase_lim = limit[REG_RESET_LOW];
         PH_RST_WAIT: phase_lim = limit[REG_PRES_WAIT];
         PH_RST_REC:  phase_lim = limit[REG_RESET_REC];
         PH_W_LOW:    phase_lim = tx_one ? limit[REG_SHORT_LOW] : limit[REG_WRITE_SLOT];
         PH_W_REL:    phase_lim = tx_one ? limit[REG_WRITE_SLOT] : limit[REG_WRITE_REC];
         PH_R_LOW:    phase_lim = limit[REG_SHORT_LOW];
         PH_R_REL:    phase_lim = limit[REG_READ_SLOT];
         default:     phase_lim = limit[REG_READ_TAIL];
      endcase
   end

   // next state for one beat
   always_comb begin
      phase_in      = phase_ff;
      tick_count_in = tick_count_ff;
      bit_index_in  = bit_index_ff;
      tx_shift_in   = tx_shift_ff;
      rx_byte_in    = rx_byte_ff;
      presence_in   = presence_ff;
      done_in       = 1'b0;

      if (phase_ff == PH_IDLE || phase_ff > PH_R_TAIL) begin
         phase_in      = PH_IDLE;
         tick_count_in = '0;
         unique case (cmd_type'(req_bus.cmd))
            CMD_RESET: begin
               phase_in = PH_RST_LOW;
            end
            CMD_WRITE: begin
               tx_shift_in  = req_bus.data_byte;
               bit_index_in = '0;
               phase_in     = PH_W_LOW;
            end
            CMD_READ: begin
               rx_byte_in   = '0;
               bit_index_in = '0;
               phase_in     = PH_R_LOW;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end else begin
         // first tick after release: sample the read bit
         if (phase_ff == PH_R_REL && tick_count_ff == '0) begin
            rx_byte_in = rx_byte_ff | (8'(req_bus.line_in) << bit_index_ff);
         end
         if (tick_count_ff < phase_lim) begin
            tick_count_in = tick_count_ff + 1'b1;
         end else begin
            tick_count_in = '0;
            unique case (phase_ff)
               PH_RST_LOW: begin
                  phase_in = PH_RST_WAIT;
               end
               PH_RST_WAIT: begin
                  presence_in = req_bus.line_in;
                  phase_in    = PH_RST_REC;
               end
               PH_W_LOW: begin
                  phase_in = PH_W_REL;
               end
               PH_W_REL: begin
                  tx_shift_in = tx_shift_ff >> 1;
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in = '0;
                     phase_in     = PH_IDLE;
                     done_in      = 1'b1;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                     phase_in     = PH_W_LOW;
                  end
               end
               PH_R_LOW: begin
                  phase_in = PH_R_REL;
               end
               PH_R_REL: begin
                  if (bit_index_ff == 3'd7) begin
                     bit_index_in = '0;
                     phase_in     = PH_R_TAIL;
                  end else begin
                     bit_index_in = bit_index_ff + 3'd1;
                     phase_in     = PH_R_LOW;
                  end
               end
               default: begin
                  // reset recovery and read tail both finish the sequence
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff  <= '0;
         tx_shift_ff   <= '0;
         rx_byte_ff    <= '0;
         presence_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         drive_low_ff  <= 1'b0;
         busy_ff       <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         if (req_beat) begin
            phase_ff      <= phase_in;
            tick_count_ff <= tick_count_in;
            bit_index_ff  <= bit_index_in;
            tx_shift_ff   <= tx_shift_in;
            rx_byte_ff    <= rx_byte_in;
            presence_ff   <= presence_in;
            drive_low_ff  <= (phase_in == PH_RST_LOW) || (phase_in == PH_W_LOW) ||
                             (phase_in == PH_R_LOW);
            busy_ff       <= (phase_in != PH_IDLE);
            done_ff       <= done_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // read_data and reset_level mirror the state, which only moves with a beat
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.drive_low   = drive_low_ff;
   assign rsp_bus.busy_res    = busy_ff;
   assign rsp_bus.done_res    = done_ff;
   assign rsp_bus.read_data   = rx_byte_ff;
   assign rsp_bus.reset_level = presence_ff;

`ifndef SYNTH
   // a finished sequence is never reported as still running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> !busy_ff && !drive_low_ff)
      else $error("done beat shows a running sequence");

   // idle always holds a cleared counter and bit index
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> tick_count_ff == '0 && bit_index_ff == '0)
      else $error("idle with stale counters");

   // the sequencer only moves on an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      !req_beat |=> $stable(phase_ff) && $stable(tick_count_ff))
      else $error("sequencer moved without a beat");
`endif

endmodule

FILE: rtl/owm_timing_regs.sv
// Timing register file with limits saturated to the counter width.
module owm_timing_regs
   import owm_pkg::*;
#(
   parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [REG_INDEX_W-1:0] csr_index,
   input  logic [REG_W-1:0]       csr_write_data,
   output logic [COUNT_WIDTH-1:0] limit [NUM_REGS]
);

   localparam int EXT_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
   localparam logic [EXT_W-1:0] COUNT_MAX_EXT =
      EXT_W'((33'd1 << COUNT_WIDTH) - 33'd1);

   logic [REG_W-1:0] regs_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= REG_DEFAULTS[i];
         end
      end else if (csr_write_en) begin
         regs_ff[csr_index] <= csr_write_data;
      end
   end

   // clamp each limit to the largest count the counter holds
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         if (EXT_W'(regs_ff[i]) > COUNT_MAX_EXT) begin
            limit[i] = COUNT_MAX_EXT[COUNT_WIDTH-1:0];
         end else begin
            limit[i] = COUNT_WIDTH'(EXT_W'(regs_ff[i]));
         end
      end
   end

endmodule
